@@ hw/rtl/aes128_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// Shared constants and byte-level functions for the AES-128 block encryptor.
// ----------------------------------------------------------------------------
package aes128_pkg;

   localparam int NumRounds = 10;
   localparam int CsrAddrWidth = 4;

   // Register byte addresses.
   localparam logic [CsrAddrWidth-1:0] CSR_KEY_HIGH = 4'h0;
   localparam logic [CsrAddrWidth-1:0] CSR_KEY_LOW  = 4'h8;

   // Forward S-box.
   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] y;
      case (x)
         8'h00: y=8'h63; 8'h01: y=8'h7c; 8'h02: y=8'h77; 8'h03: y=8'h7b;
         8'h04: y=8'hf2; 8'h05: y=8'h6b; 8'h06: y=8'h6f; 8'h07: y=8'hc5;
         8'h08: y=8'h30; 8'h09: y=8'h01; 8'h0a: y=8'h67; 8'h0b: y=8'h2b;
         8'h0c: y=8'hfe; 8'h0d: y=8'hd7; 8'h0e: y=8'hab; 8'h0f: y=8'h76;
         8'h10: y=8'hca; 8'h11: y=8'h82; 8'h12: y=8'hc9; 8'h13: y=8'h7d;
         8'h14: y=8'hfa; 8'h15: y=8'h59; 8'h16: y=8'h47; 8'h17: y=8'hf0;
         8'h18: y=8'had; 8'h19: y=8'hd4; 8'h1a: y=8'ha2; 8'h1b: y=8'haf;
         8'h1c: y=8'h9c; 8'h1d: y=8'ha4; 8'h1e: y=8'h72; 8'h1f: y=8'hc0;
         8'h20: y=8'hb7; 8'h21: y=8'hfd; 8'h22: y=8'h93; 8'h23: y=8'h26;
         8'h24: y=8'h36; 8'h25: y=8'h3f; 8'h26: y=8'hf7; 8'h27: y=8'hcc;
         8'h28: y=8'h34; 8'h29: y=8'ha5; 8'h2a: y=8'he5; 8'h2b: y=8'hf1;
         8'h2c: y=8'h71; 8'h2d: y=8'hd8; 8'h2e: y=8'h31; 8'h2f: y=8'h15;
         8'h30: y=8'h04; 8'h31: y=8'hc7; 8'h32: y=8'h23; 8'h33: y=8'hc3;
         8'h34: y=8'h18; 8'h35: y=8'h96; 8'h36: y=8'h05; 8'h37: y=8'h9a;
         8'h38: y=8'h07; 8'h39: y=8'h12; 8'h3a: y=8'h80; 8'h3b: y=8'he2;
         8'h3c: y=8'heb; 8'h3d: y=8'h27; 8'h3e: y=8'hb2; 8'h3f: y=8'h75;
         8'h40: y=8'h09; 8'h41: y=8'h83; 8'h42: y=8'h2c; 8'h43: y=8'h1a;
         8'h44: y=8'h1b; 8'h45: y=8'h6e; 8'h46: y=8'h5a; 8'h47: y=8'ha0;
         8'h48: y=8'h52; 8'h49: y=8'h3b; 8'h4a: y=8'hd6; 8'h4b: y=8'hb3;
         8'h4c: y=8'h29; 8'h4d: y=8'he3; 8'h4e: y=8'h2f; 8'h4f: y=8'h84;
         8'h50: y=8'h53; 8'h51: y=8'hd1; 8'h52: y=8'h00; 8'h53: y=8'hed;
         8'h54: y=8'h20; 8'h55: y=8'hfc; 8'h56: y=8'hb1; 8'h57: y=8'h5b;
         8'h58: y=8'h6a; 8'h59: y=8'hcb; 8'h5a: y=8'hbe; 8'h5b: y=8'h39;
         8'h5c: y=8'h4a; 8'h5d: y=8'h4c; 8'h5e: y=8'h58; 8'h5f: y=8'hcf;
         8'h60: y=8'hd0; 8'h61: y=8'hef; 8'h62: y=8'haa; 8'h63: y=8'hfb;
         8'h64: y=8'h43; 8'h65: y=8'h4d; 8'h66: y=8'h33; 8'h67: y=8'h85;
         8'h68: y=8'h45; 8'h69: y=8'hf9; 8'h6a: y=8'h02; 8'h6b: y=8'h7f;
         8'h6c: y=8'h50; 8'h6d: y=8'h3c; 8'h6e: y=8'h9f; 8'h6f: y=8'ha8;
         8'h70: y=8'h51; 8'h71: y=8'ha3; 8'h72: y=8'h40; 8'h73: y=8'h8f;
         8'h74: y=8'h92; 8'h75: y=8'h9d; 8'h76: y=8'h38; 8'h77: y=8'hf5;
         8'h78: y=8'hbc; 8'h79: y=8'hb6; 8'h7a: y=8'hda; 8'h7b: y=8'h21;
         8'h7c: y=8'h10; 8'h7d: y=8'hff; 8'h7e: y=8'hf3; 8'h7f: y=8'hd2;
         8'h80: y=8'hcd; 8'h81: y=8'h0c; 8'h82: y=8'h13; 8'h83: y=8'hec;
         8'h84: y=8'h5f; 8'h85: y=8'h97; 8'h86: y=8'h44; 8'h87: y=8'h17;
         8'h88: y=8'hc4; 8'h89: y=8'ha7; 8'h8a: y=8'h7e; 8'h8b: y=8'h3d;
         8'h8c: y=8'h64; 8'h8d: y=8'h5d; 8'h8e: y=8'h19; 8'h8f: y=8'h73;
         8'h90: y=8'h60; 8'h91: y=8'h81; 8'h92: y=8'h4f; 8'h93: y=8'hdc;
         8'h94: y=8'h22; 8'h95: y=8'h2a; 8'h96: y=8'h90; 8'h97: y=8'h88;
         8'h98: y=8'h46; 8'h99: y=8'hee; 8'h9a: y=8'hb8; 8'h9b: y=8'h14;
         8'h9c: y=8'hde; 8'h9d: y=8'h5e; 8'h9e: y=8'h0b; 8'h9f: y=8'hdb;
         8'ha0: y=8'he0; 8'ha1: y=8'h32; 8'ha2: y=8'h3a; 8'ha3: y=8'h0a;
         8'ha4: y=8'h49; 8'ha5: y=8'h06; 8'ha6: y=8'h24; 8'ha7: y=8'h5c;
         8'ha8: y=8'hc2; 8'ha9: y=8'hd3; 8'haa: y=8'hac; 8'hab: y=8'h62;
         8'hac: y=8'h91; 8'had: y=8'h95; 8'hae: y=8'he4; 8'haf: y=8'h79;
         8'hb0: y=8'he7; 8'hb1: y=8'hc8; 8'hb2: y=8'h37; 8'hb3: y=8'h6d;
         8'hb4: y=8'h8d; 8'hb5: y=8'hd5; 8'hb6: y=8'h4e; 8'hb7: y=8'ha9;
         8'hb8: y=8'h6c; 8'hb9: y=8'h56; 8'hba: y=8'hf4; 8'hbb: y=8'hea;
         8'hbc: y=8'h65; 8'hbd: y=8'h7a; 8'hbe: y=8'hae; 8'hbf: y=8'h08;
         8'hc0: y=8'hba; 8'hc1: y=8'h78; 8'hc2: y=8'h25; 8'hc3: y=8'h2e;
         8'hc4: y=8'h1c; 8'hc5: y=8'ha6; 8'hc6: y=8'hb4; 8'hc7: y=8'hc6;
         8'hc8: y=8'he8; 8'hc9: y=8'hdd; 8'hca: y=8'h74; 8'hcb: y=8'h1f;
         8'hcc: y=8'h4b; 8'hcd: y=8'hbd; 8'hce: y=8'h8b; 8'hcf: y=8'h8a;
         8'hd0: y=8'h70; 8'hd1: y=8'h3e; 8'hd2: y=8'hb5; 8'hd3: y=8'h66;
         8'hd4: y=8'h48; 8'hd5: y=8'h03; 8'hd6: y=8'hf6; 8'hd7: y=8'h0e;
         8'hd8: y=8'h61; 8'hd9: y=8'h35; 8'hda: y=8'h57; 8'hdb: y=8'hb9;
         8'hdc: y=8'h86; 8'hdd: y=8'hc1; 8'hde: y=8'h1d; 8'hdf: y=8'h9e;
         8'he0: y=8'he1; 8'he1: y=8'hf8; 8'he2: y=8'h98; 8'he3: y=8'h11;
         8'he4: y=8'h69; 8'he5: y=8'hd9; 8'he6: y=8'h8e; 8'he7: y=8'h94;
         8'he8: y=8'h9b; 8'he9: y=8'h1e; 8'hea: y=8'h87; 8'heb: y=8'he9;
         8'hec: y=8'hce; 8'hed: y=8'h55; 8'hee: y=8'h28; 8'hef: y=8'hdf;
         8'hf0: y=8'h8c; 8'hf1: y=8'ha1; 8'hf2: y=8'h89; 8'hf3: y=8'h0d;
         8'hf4: y=8'hbf; 8'hf5: y=8'he6; 8'hf6: y=8'h42; 8'hf7: y=8'h68;
         8'hf8: y=8'h41; 8'hf9: y=8'h99; 8'hfa: y=8'h2d; 8'hfb: y=8'h0f;
         8'hfc: y=8'hb0; 8'hfd: y=8'h54; 8'hfe: y=8'hbb; default: y=8'h16;
      endcase
      return y;
   endfunction

   // Round constant for round r (1..10).
   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] y;
      case (r)
         4'd1: y = 8'h01; 4'd2: y = 8'h02; 4'd3: y = 8'h04; 4'd4: y = 8'h08;
         4'd5: y = 8'h10; 4'd6: y = 8'h20; 4'd7: y = 8'h40; 4'd8: y = 8'h80;
         4'd9: y = 8'h1b; 4'd10: y = 8'h36;
         default: y = 8'h00;
      endcase
      return y;
   endfunction

   // Multiply by two in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of a 128-bit block, byte 0 most significant.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
      return s[127 - 8*k -: 8];
   endfunction

   // One round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic do_mix);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[c*4 + r] = sbox(get_byte(s, ((c + r) % 4)*4 + r));
         end
      end
      if (do_mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            t[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
      end
      for (int k = 0; k < 16; k++) begin
         o[127 - 8*k -: 8] = t[k];
      end
      return o ^ rk;
   endfunction

   // Next round key from the previous one.
   function automatic logic [127:0] next_key(input logic [127:0] k,
                                              input logic [3:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]),
            sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

@@ hw/rtl/aes128_keysched.sv @@
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Carries each block's round keys down the pipeline beside its state.
// ----------------------------------------------------------------------------
module aes128_keysched (
   input  logic         clock,
   input  logic [127:0] key,
   input  logic         move [11],
   output logic [127:0] round_key [11]
);
   import aes128_pkg::*;

   logic [127:0] rk_ff [NumRounds];

   // Stage 0 uses the cipher key itself. Each later stage derives its round
   // key from the key that the same block held one stage earlier.
   always_comb begin
      round_key[0] = key;
      for (int r = 1; r <= NumRounds; r++) begin
         round_key[r] = next_key(rk_ff[r-1], 4'(r));
      end
   end

   // The key registers advance together with the state registers, so a new
   // key reaches only the blocks that enter after it was written.
   always_ff @(posedge clock) begin
      if (move[0]) rk_ff[0] <= key;
      for (int r = 1; r < NumRounds; r++) begin
         if (move[r]) rk_ff[r] <= round_key[r];
      end
   end

endmodule

@@ hw/rtl/aes128_block_encrypt_top.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encryptor, top level
// Pipelined AES-128 encryption of 128-bit blocks under a register-held key.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through the csr_ port: key_high at byte address 0,
//   key_low at byte address 8, 64-bit data. Write the key only while the
//   pipeline is empty. The round keys travel down the pipeline with their
//   block, so a new key applies from the next request on.
//   A request on req_ is accepted when req_valid is high and req_stall low.
//   The ciphertext leaves on rsp_ and is taken when rsp_valid is high and
//   rsp_stall low.
//   Throughput is one block per cycle while rsp_stall is low. There are 11
//   register stages: one for the initial AddRoundKey and one per round; a
//   block passes through all of them in order before rsp_valid rises for
//   it, and its result is taken at an edge where rsp_stall is low.
//   On a receiver stall, each full stage with no bubble after it holds; a
//   bubble ahead of the output may still fill, so none is lost or repeated.
//   Reset clears all valid bits and both key registers.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [63:0]                          req_plain_high,
   input  logic [63:0]                          req_plain_low,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_cipher_high,
   output logic [63:0]                          rsp_cipher_low,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [aes128_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [63:0]                          pwdata,
   output logic [63:0]                          prdata,
   output logic                                 pready
);
   import aes128_pkg::*;

   logic [63:0]  key_high_ff, key_low_ff;
   logic [127:0] round_key [11];
   logic         valid_ff [11];
   logic [127:0] state_ff [11];
   logic         move [11];

   // Register write and read.
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr == CSR_KEY_HIGH) key_high_ff <= pwdata;
         if (paddr == CSR_KEY_LOW)  key_low_ff  <= pwdata;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_KEY_HIGH) prdata = key_high_ff;
      if (paddr == CSR_KEY_LOW)  prdata = key_low_ff;
   end

   aes128_keysched u_keysched (
      .clock     (clock),
      .key       ({key_high_ff, key_low_ff}),
      .move      (move),
      .round_key (round_key)
   );

   // A stage moves when its output slot is empty or being drained.
   always_comb begin
      move[NumRounds] = !valid_ff[NumRounds] || !rsp_stall;
      for (int s = NumRounds - 1; s >= 0; s--) begin
         move[s] = !valid_ff[s] || move[s+1];
      end
   end

   assign req_stall = !move[0];

   // Stage 0 adds the first round key; stages 1..10 run one round each.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NumRounds; s++) valid_ff[s] <= 1'b0;
      end else begin
         if (move[0]) valid_ff[0] <= req_valid;
         for (int s = 1; s <= NumRounds; s++) begin
            if (move[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) state_ff[0] <= {req_plain_high, req_plain_low} ^ round_key[0];
      for (int s = 1; s <= NumRounds; s++) begin
         if (move[s]) begin
            state_ff[s] <= aes_round(state_ff[s-1], round_key[s], s != NumRounds);
         end
      end
   end

   assign rsp_valid       = valid_ff[NumRounds];
   assign rsp_cipher_high = state_ff[NumRounds][127:64];
   assign rsp_cipher_low  = state_ff[NumRounds][63:0];

endmodule

@@ hw/rtl/aes128_checker.sv @@
// ----------------------------------------------------------------------------
// AES-128 port checker
// Watches the top-level ports for handshake and pipeline consistency.
// ----------------------------------------------------------------------------
module aes128_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_cipher_high,
   input logic [63:0] rsp_cipher_low,
   input logic        pready
);
   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_high)
                                 && $stable(rsp_cipher_low))
      else $error("stalled response changed");

   // The input only stalls while the output is backed up.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   // Nothing appears at the output right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // The register port never waits.
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind aes128_block_encrypt_top aes128_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_cipher_high (rsp_cipher_high),
   .rsp_cipher_low  (rsp_cipher_low),
   .pready          (pready)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encryptor testbench
// Drives plaintext requests under several keys, predicts each ciphertext with
// a self-contained AES-128 model and checks every response in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import aes128_pkg::*;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_plain_high;
   logic [63:0] req_plain_low;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   aes128_block_encrypt_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_plain_high(req_plain_high), .req_plain_low(req_plain_low),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cipher_high(rsp_cipher_high), .rsp_cipher_low(rsp_cipher_low),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Key as the predictor sees it.
   logic [63:0] model_key_hi;
   logic [63:0] model_key_lo;

   block_type plain_queue[$];
   block_type cipher_queue[$];
   int        error_count;
   int        send_idle_pct;
   int        stall_pct;

   // Set at each rising edge that accepted a request.
   logic      req_accepted;

   // S-box table, filled once at start.
   logic [7:0] sub_table [256];

   // Multiply by two in GF(2^8).
   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return (x << 1) ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Full AES-128 encryption of one block under the model key.
   function automatic block_type encrypt_block(input block_type pt);
      logic [7:0] w [176];
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] tw [4];
      logic [7:0] s, a0, a1, a2, a3, rc;
      block_type  ct;
      rc = 8'h01;
      for (int k = 0; k < 8; k++) begin
         w[k]     = model_key_hi[63-8*k -: 8];
         w[k+8]   = model_key_lo[63-8*k -: 8];
         b[k]     = pt.hi[63-8*k -: 8];
         b[k+8]   = pt.lo[63-8*k -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) tw[j] = w[(i-1)*4+j];
         if (i % 4 == 0) begin
            s = tw[0];
            tw[0] = sub_table[tw[1]] ^ rc;
            tw[1] = sub_table[tw[2]];
            tw[2] = sub_table[tw[3]];
            tw[3] = sub_table[s];
            rc = gf_double(rc);
         end
         for (int j = 0; j < 4; j++) w[i*4+j] = w[(i-4)*4+j] ^ tw[j];
      end
      for (int k = 0; k < 16; k++) b[k] ^= w[k];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
               t[c*4+q] = sub_table[b[((c+q)%4)*4+q]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
               t[c*4]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
               t[c*4+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
               t[c*4+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
               t[c*4+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
         end
         for (int k = 0; k < 16; k++) b[k] = t[k] ^ w[r*16+k];
      end
      for (int k = 0; k < 8; k++) begin
         ct.hi[63-8*k -: 8] = b[k];
         ct.lo[63-8*k -: 8] = b[k+8];
      end
      return ct;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Request driver: presents the oldest pending plaintext at falling edges.
   // The front of the queue is the request on the port until it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (req_valid) void'(plain_queue.pop_front());
         if (plain_queue.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_plain_high <= plain_queue[0].hi;
            req_plain_low  <= plain_queue[0].lo;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, chosen at falling edges.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Predict on each accepted request; check on each accepted response.
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            cipher_queue.push_back(encrypt_block({req_plain_high, req_plain_low}));
         if (rsp_valid && !rsp_stall) begin
            if (cipher_queue.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               if (rsp_cipher_high !== cipher_queue[0].hi)
                  report_mismatch($sformatf("cipher_high got %h expected %h",
                                            rsp_cipher_high, cipher_queue[0].hi));
               if (rsp_cipher_low !== cipher_queue[0].lo)
                  report_mismatch($sformatf("cipher_low got %h expected %h",
                                            rsp_cipher_low, cipher_queue[0].lo));
               void'(cipher_queue.pop_front());
            end
         end
      end
   end

   // Write one key register while the pipeline is empty.
   task automatic write_key(input logic [CsrAddrWidth-1:0] addr,
                            input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == CSR_KEY_HIGH) model_key_hi = value;
      else model_key_lo = value;
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      write_key(CSR_KEY_HIGH, hi);
      write_key(CSR_KEY_LOW, lo);
      // Leave a short gap after the key write.
      repeat (16) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (plain_queue.size() != 0 || req_valid) @(posedge clock);
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random plaintext with occasional all-zero or all-one halves.
   function automatic block_type rand_block();
      block_type v;
      v.hi = rand64();
      v.lo = rand64();
      case ($urandom_range(9))
         0: v.hi = '0;
         1: v.lo = '1;
         default: ;
      endcase
      return v;
   endfunction

   // Stimulus and phase control.
   initial begin
      error_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      req_accepted = 1'b0;
      model_key_hi = '0;
      model_key_lo = '0;
      for (int i = 0; i < 256; i++) sub_table[i] = sbox(i[7:0]);
      reset = 1'b1;
      req_valid = 1'b0; req_plain_high = '0; req_plain_low = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset key (all zero), extreme plaintexts.
      plain_queue.push_back('{64'h0, 64'h0});
      plain_queue.push_back('{64'hffffffffffffffff, 64'hffffffffffffffff});
      wait_drained();
      // Standard example key and block, then walking bits.
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      plain_queue.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff});
      for (int k = 0; k < 8; k++)
         plain_queue.push_back('{64'h1 << (8*k+3), ~(64'h1 << (8*k))});
      wait_drained();
      // Extreme keys; a key change applies from the next block on.
      load_key('1, '1);
      plain_queue.push_back('{64'h0, 64'h0});
      plain_queue.push_back('{64'hffffffffffffffff, 64'h0});
      wait_drained();
      load_key('0, '1);
      plain_queue.push_back('{64'h8000000000000001, 64'h0123456789abcdef});
      wait_drained();

      // Random phases with different idle patterns and keys.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         load_key(rand64(), rand64());
         for (int n = 0; n < 88; n++) plain_queue.push_back(rand_block());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

   // Watchdog.
   initial begin
      #2ms;
      $display("testbench: done, errors");
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_keysched.sv
hw/rtl/aes128_block_encrypt_top.sv
hw/rtl/aes128_checker.sv
tb/testbench.sv
